>>> rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/ffa_pkg.sv
// Package: types and constants for the first-fit free block allocator.
package ffa_pkg;
  localparam int FREE_SLOTS_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 20;
  localparam int POOL_BITS       = 21;
  localparam int COUNT_BITS      = 7;
  localparam logic [POOL_BITS-1:0] POOL_RESET = 21'd500000;

  localparam logic       FUNC_ALLOC = 1'b0;
  localparam logic       FUNC_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic        func;
    logic [20:0] block_size;
    logic [19:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] alloc_offset;
    logic [6:0]  free_blocks;
  } out_item_t;
endpackage

>>> rtl/ffa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/first_fit_free_block_allocator.sv
// Top level: first-fit free block allocator with coalescing.
//
// Usage: raise start with in_item while busy is low; the transaction is
// taken at that edge and busy rises the next cycle. One result per
// transaction appears on out_item for exactly one cycle with out_valid
// high; the receiver cannot hold it off. busy falls in that same cycle, so
// the next transaction may be taken at the edge that takes the result.
// The table of free blocks (start, length) sits in one RAM of width
// 2*OFFSET_BITS+1 and depth FREE_SLOTS, read through its registered port.
// Sequencing: every search, remove shift and insert shift walks the
// table entry by entry, a read state and then a check or write state
// for each entry, behind the registered read port. A zero-size free
// goes straight to its result; the other transactions take longer as
// the table fills.
// One transaction is in flight at a time.
// Reset: entry 0 is written with the block [0, 500000) while rst_n is low;
// entries past the count are never used. Writing cfg_pool_size (while
// idle) reloads the table as one block of that size, clamped to
// 2^OFFSET_BITS; a size of zero empties it.
module first_fit_free_block_allocator #(
  parameter int FREE_SLOTS  = ffa_pkg::FREE_SLOTS_DEF,
  parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ffa_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output ffa_pkg::out_item_t   out_item,
  input  logic                 cfg_we,
  input  logic [20:0]          cfg_pool_size
);
  localparam int AW = $clog2(FREE_SLOTS);
  localparam int CW = AW + 1;
  localparam int OW = OFFSET_BITS;
  localparam int LW = OFFSET_BITS + 1;
  localparam int EW = OW + LW;
  localparam logic [LW-1:0] LIMIT = LW'(1) << OW;
  localparam logic [LW-1:0] RESET_POOL = (ffa_pkg::POOL_RESET > LIMIT) ? LIMIT
                                       : LW'(ffa_pkg::POOL_RESET);

  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ARD    = 4'd1;  // alloc search: read issued
  localparam logic [3:0] S_ACHK   = 4'd2;  // alloc search: data back
  localparam logic [3:0] S_FRD    = 4'd3;  // free search: read issued
  localparam logic [3:0] S_FCHK   = 4'd4;  // free search: data back
  localparam logic [3:0] S_PRV    = 4'd5;  // read lower neighbour
  localparam logic [3:0] S_PRVCHK = 4'd6;
  localparam logic [3:0] S_RMRD   = 4'd7;  // remove: read k+1
  localparam logic [3:0] S_RMWR   = 4'd8;  // remove: write k
  localparam logic [3:0] S_INS    = 4'd9;  // insert setup: search
  localparam logic [3:0] S_INSCHK = 4'd10;
  localparam logic [3:0] S_SHRD   = 4'd11; // insert: read k-1
  localparam logic [3:0] S_SHWR   = 4'd12; // insert: write k
  localparam logic [3:0] S_DONE   = 4'd13;

  // after-remove follow-up codes
  localparam logic [1:0] NX_NONE   = 2'd0;
  localparam logic [1:0] NX_INS    = 2'd1; // insert ins_s/ins_l

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // search index / shift index
  logic [CW-1:0] pos_r, pos_nxt;     // found position
  logic          func_r, func_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [OW-1:0] ins_s_r, ins_s_nxt;
  logic [LW-1:0] ins_l_r, ins_l_nxt;
  logic [LW-1:0] nlen_r, nlen_nxt;
  logic [1:0]    follow_r, follow_nxt;
  logic          isfull_r, isfull_nxt; // insert outcome reported in status
  logic [1:0]    st_r, st_nxt;
  logic [OW-1:0] where_r, where_nxt;
  logic [EW-1:0] hold_r, hold_nxt;   // entry at the free search position
  logic          ov_r, ov_nxt;
  ffa_pkg::out_item_t oi_r, oi_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [OW-1:0] rd_s;
  logic [LW-1:0] rd_l;

  ffa_ram #(.WIDTH(EW), .DEPTH(FREE_SLOTS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rd_s = rdata[EW-1:LW];
  assign rd_l = rdata[LW-1:0];

  logic [LW-1:0] clamp_pool;
  logic [LW-1:0] cfg_ext;
  assign cfg_ext    = (21 > LW && |(cfg_pool_size >> LW)) ? LIMIT : LW'(cfg_pool_size);
  assign clamp_pool = (cfg_ext > LIMIT) ? LIMIT : cfg_ext;

  logic [LW-1:0] in_size_w;
  logic [OW-1:0] in_off_w;
  logic [LW-1:0] room;
  logic [LW-1:0] fsize;
  assign in_size_w = (21 > LW && |(in_item.block_size >> LW)) ? LIMIT
                   : LW'(in_item.block_size);
  assign in_off_w  = OW'(in_item.free_offset);
  assign room      = LIMIT - LW'(in_off_w);
  assign fsize     = (in_size_w > room) ? room : in_size_w;

  logic [LW:0] end_sum;
  assign end_sum = (LW+1)'(off_r) + (LW+1)'(size_r);

  // adjacency of the freed block to its lower and higher neighbours
  logic lo_w, hi_w;
  assign lo_w = (pos_r != '0) &&
                ((LW+1)'(rd_s) + (LW+1)'(rd_l) == (LW+1)'(off_r));
  assign hi_w = (pos_r < count_r) && (end_sum == (LW+1)'(hold_r[EW-1:LW]));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    func_nxt   = func_r;
    size_nxt   = size_r;
    off_nxt    = off_r;
    ins_s_nxt  = ins_s_r;
    ins_l_nxt  = ins_l_r;
    nlen_nxt   = nlen_r;
    follow_nxt = follow_r;
    isfull_nxt = isfull_r;
    st_nxt     = st_r;
    where_nxt  = where_r;
    hold_nxt   = hold_r;
    ov_nxt     = 1'b0;
    oi_nxt     = oi_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          we    = 1'b1;
          wdata = {OW'(0), clamp_pool};
          count_nxt = (clamp_pool == '0) ? CW'(0) : CW'(1);
        end
        if (start) begin
          func_nxt  = in_item.func;
          idx_nxt   = '0;
          where_nxt = '0;
          follow_nxt = NX_NONE;
          if (in_item.func == ffa_pkg::FUNC_ALLOC) begin
            size_nxt  = in_size_w;
            state_nxt = S_ARD;
          end else begin
            size_nxt = fsize;
            off_nxt  = in_off_w;
            if (fsize == '0) begin
              st_nxt    = ffa_pkg::ST_IGNORED;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_ARD: begin
        if (idx_r >= count_r) begin
          st_nxt    = ffa_pkg::ST_NOFIT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (rd_l >= size_r) begin
          where_nxt = rd_s;
          st_nxt    = ffa_pkg::ST_OK;
          pos_nxt   = idx_r;
          if (rd_l == size_r) begin
            follow_nxt = NX_NONE;
          end else begin
            follow_nxt = NX_INS;
            ins_s_nxt  = OW'((LW+1)'(rd_s) + (LW+1)'(size_r));
            ins_l_nxt  = rd_l - size_r;
          end
          isfull_nxt = 1'b0; // insert status not reported for alloc
          state_nxt  = S_RMRD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_ARD;
        end
      end
      S_FRD: begin
        state_nxt = (idx_r >= count_r) ? S_PRV : S_FCHK;
      end
      S_FCHK: begin
        if (rd_s >= off_r) begin
          nlen_nxt  = rd_l;
          hold_nxt  = rdata; // next entry
          state_nxt = S_PRV;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_FRD;
        end
      end
      S_PRV: begin
        // idx_r = nx; read nx-1
        pos_nxt = idx_r;
        raddr   = AW'(idx_r - CW'(1));
        state_nxt = S_PRVCHK;
      end
      S_PRVCHK: begin
        st_nxt = ffa_pkg::ST_OK;
        if (lo_w) begin
          we    = 1'b1;
          waddr = AW'(pos_r - CW'(1));
          wdata = {rd_s, rd_l + size_r + (hi_w ? nlen_r : LW'(0))};
        end
        if (hi_w) begin
          follow_nxt = lo_w ? NX_NONE : NX_INS;
          ins_s_nxt  = off_r;
          ins_l_nxt  = size_r + nlen_r;
          idx_nxt    = pos_r;
          isfull_nxt = 1'b1;
          state_nxt  = S_RMRD;
        end else if (lo_w) begin
          state_nxt = S_DONE;
        end else begin
          ins_s_nxt  = off_r;
          ins_l_nxt  = size_r;
          isfull_nxt = 1'b1;
          idx_nxt    = pos_r;
          state_nxt  = S_INSCHK;
        end
      end
      S_RMRD: begin
        // remove entry pos: copy k+1 -> k for k from pos
        if (pos_r + CW'(1) >= count_r) begin
          count_nxt = count_r - CW'(1);
          idx_nxt   = '0;
          state_nxt = (follow_r == NX_INS) ? S_INS : S_DONE;
        end else begin
          raddr     = AW'(pos_r + CW'(1));
          state_nxt = S_RMWR;
        end
      end
      S_RMWR: begin
        we        = 1'b1;
        waddr     = AW'(pos_r);
        wdata     = rdata;
        pos_nxt   = pos_r + CW'(1);
        state_nxt = S_RMRD;
      end
      S_INS: begin
        // search lower_index(ins_s) with idx
        if (idx_r >= count_r) begin
          pos_nxt   = idx_r;
          state_nxt = S_INSCHK;
        end else begin
          state_nxt = S_INSCHK;
          pos_nxt   = {CW{1'b1}};
        end
      end
      S_INSCHK: begin
        // pos all ones: entry idx data valid, compare
        if (pos_r == {CW{1'b1}}) begin
          if (rd_s >= ins_s_r) begin
            pos_nxt = idx_r;
            if (rd_s == ins_s_r) begin
              if (isfull_r) st_nxt = ffa_pkg::ST_IGNORED;
              state_nxt = S_DONE;
            end else if (count_r >= CW'(FREE_SLOTS)) begin
              if (isfull_r) st_nxt = ffa_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_SHRD;
            end
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_INS;
          end
        end else begin
          // pos known (end of table or from free search)
          if (pos_r < count_r && idx_r == pos_r && hold_r[EW-1:LW] == ins_s_r
              && isfull_r && follow_r == NX_NONE) begin
            st_nxt    = ffa_pkg::ST_IGNORED;
            state_nxt = S_DONE;
          end else if (count_r >= CW'(FREE_SLOTS)) begin
            if (isfull_r) st_nxt = ffa_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHRD;
          end
        end
      end
      S_SHRD: begin
        if (idx_r == pos_r) begin
          we        = 1'b1;
          waddr     = AW'(pos_r);
          wdata     = {ins_s_r, ins_l_r};
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          raddr     = AW'(idx_r - CW'(1));
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we        = 1'b1;
        waddr     = AW'(idx_r);
        wdata     = rdata;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        oi_nxt.status       = st_r;
        oi_nxt.alloc_offset = (st_r == ffa_pkg::ST_OK && func_r == ffa_pkg::FUNC_ALLOC)
                            ? 20'(where_r) : 20'd0;
        oi_nxt.free_blocks  = (count_r > CW'(127)) ? 7'd127 : 7'(count_r);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // while reset is held, entry 0 is loaded with the reset pool block
    if (!rst_n) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {OW'(0), RESET_POOL};
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    func_r   <= func_nxt;
    size_r   <= size_nxt;
    off_r    <= off_nxt;
    ins_s_r  <= ins_s_nxt;
    ins_l_r  <= ins_l_nxt;
    nlen_r   <= nlen_nxt;
    follow_r <= follow_nxt;
    isfull_r <= isfull_nxt;
    st_r     <= st_nxt;
    where_r  <= where_nxt;
    hold_r   <= hold_nxt;
    oi_r     <= oi_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

`include "assert_macros.svh"
  `ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(FREE_SLOTS), "count overflow")
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE, "result while busy")
endmodule

>>> tb/first_fit_checker.sv
// Checker for the first-fit allocator: predicts each result and compares it.
`timescale 1ns / 100ps

module first_fit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ffa_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  ffa_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [20:0]        cfg_pool_size,
  output int                 fail_count,
  output int                 pending
);
  localparam int          SLOTS = ffa_pkg::FREE_SLOTS_DEF;
  localparam int unsigned LIMIT = 32'd1 << ffa_pkg::OFFSET_BITS_DEF;

  // Shadow copy of the free table
  int unsigned tbl_start [SLOTS];
  int unsigned tbl_len   [SLOTS];
  int          tbl_count;

  ffa_pkg::out_item_t expected_replies [$];

  function automatic void load_pool(int unsigned size);
    if (size > LIMIT) size = LIMIT;
    tbl_start[0] = 0;
    tbl_len[0]   = size;
    tbl_count    = (size == 0) ? 0 : 1;
  endfunction

  // First entry whose start is at or above s
  function automatic int first_at_or_above(int unsigned s);
    int i;
    i = 0;
    while (i < tbl_count && tbl_start[i] < s) i++;
    return i;
  endfunction

  function automatic void drop_entry(int i);
    for (int k = i; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k]   = tbl_len[k+1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic logic [1:0] add_entry(int unsigned s, int unsigned len);
    int i;
    i = first_at_or_above(s);
    if (i < tbl_count && tbl_start[i] == s) return ffa_pkg::ST_IGNORED;
    if (tbl_count >= SLOTS) return ffa_pkg::ST_FULL;
    for (int k = tbl_count; k > i; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k]   = tbl_len[k-1];
    end
    tbl_start[i] = s;
    tbl_len[i]   = len;
    tbl_count++;
    return ffa_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] take_block(int unsigned need, output int unsigned where);
    int unsigned s, len;
    where = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_len[i] >= need) begin
        s     = tbl_start[i];
        len   = tbl_len[i];
        where = s;
        drop_entry(i);
        // remainder landing on an existing start is silently lost
        if (len != need) void'(add_entry(s + need, len - need));
        return ffa_pkg::ST_OK;
      end
    end
    return ffa_pkg::ST_NOFIT;
  endfunction

  function automatic logic [1:0] release_block(int unsigned off, int unsigned size);
    int          nx;
    bit          merged;
    int unsigned fin, nlen;
    merged = 0;
    off    = off & (LIMIT - 1);
    if (size > LIMIT - off) size = LIMIT - off;
    if (size == 0) return ffa_pkg::ST_IGNORED;
    nx = first_at_or_above(off);
    if (nx > 0 && tbl_start[nx-1] + tbl_len[nx-1] == off) begin
      tbl_len[nx-1] += size;
      merged = 1;
    end
    fin = off + size;
    if (nx < tbl_count && fin == tbl_start[nx]) begin
      nlen = tbl_len[nx];
      drop_entry(nx);
      if (merged) begin
        tbl_len[nx-1] += nlen;
        return ffa_pkg::ST_OK;
      end
      return add_entry(off, size + nlen);
    end
    if (!merged) return add_entry(off, size);
    return ffa_pkg::ST_OK;
  endfunction

  function automatic ffa_pkg::out_item_t predict_reply(ffa_pkg::in_item_t it);
    ffa_pkg::out_item_t r;
    int unsigned        where;
    where = 0;
    if (it.func == ffa_pkg::FUNC_ALLOC) begin
      r.status = take_block(32'(it.block_size), where);
      if (r.status != ffa_pkg::ST_OK) where = 0;
    end else begin
      r.status = release_block(32'(it.free_offset), 32'(it.block_size));
    end
    r.alloc_offset = where[19:0];
    r.free_blocks  = (tbl_count > 127) ? 7'd127 : tbl_count[6:0];
    return r;
  endfunction

  // Track config and transactions; compare results against the oldest prediction
  always @(posedge clk) begin
    ffa_pkg::out_item_t exp_r;
    if (!rst_n) begin
      load_pool(32'(ffa_pkg::POOL_RESET));
      expected_replies.delete();
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, out_item);
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_item.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_item.status);
            fail_count++;
          end
          if (out_item.alloc_offset !== exp_r.alloc_offset) begin
            $display("%0t: alloc_offset expected %0d actual %0d", $time,
                     exp_r.alloc_offset, out_item.alloc_offset);
            fail_count++;
          end
          if (out_item.free_blocks !== exp_r.free_blocks) begin
            $display("%0t: free_blocks expected %0d actual %0d", $time,
                     exp_r.free_blocks, out_item.free_blocks);
            fail_count++;
          end
        end
      end
      if (cfg_we) load_pool(32'(cfg_pool_size));
      if (start && !busy) expected_replies = {expected_replies, predict_reply(in_item)};
    end
    pending = expected_replies.size();
  end

endmodule

>>> tb/tb_first_fit_free_block_allocator.sv
// Testbench top for the first-fit allocator: stimulus, config phases and verdict.
`timescale 1ns / 100ps

module tb_first_fit_free_block_allocator;
  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ffa_pkg::in_item_t  in_item;
  logic               out_valid;
  ffa_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [20:0]        cfg_pool_size;
  int                 fail_count;
  int                 pending;

  // Blocks the stimulus currently holds, for well-formed frees
  int unsigned held_off [$];
  int unsigned held_len [$];
  bit          no_gaps;
  int unsigned pool_now;

  first_fit_free_block_allocator u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_pool_size(cfg_pool_size)
  );

  first_fit_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_pool_size(cfg_pool_size),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Send one transaction, then wait for its result and note any allocation
  task automatic issue(logic func, int unsigned size, int unsigned off);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    repeat (gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= '{func: func, block_size: size[20:0], free_offset: off[19:0]};
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!out_valid);
    if (func == ffa_pkg::FUNC_ALLOC && out_item.status == ffa_pkg::ST_OK && size != 0) begin
      held_off = {held_off, 32'(out_item.alloc_offset)};
      held_len = {held_len, size};
    end
  endtask

  task automatic write_pool(int unsigned size);
    repeat (8) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_pool_size <= size[20:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    held_off.delete();
    held_len.delete();
    pool_now = (size > (1 << 20)) ? (1 << 20) : size;
  endtask

  task automatic free_held(int idx);
    issue(ffa_pkg::FUNC_FREE, held_len[idx], held_off[idx]);
    held_off.delete(idx);
    held_len.delete(idx);
  endtask

  // Mostly well-formed alloc/free traffic on a granule grid, some noise
  task automatic random_phase(int n, int unsigned gran);
    int unsigned sz, off;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if (held_off.size() > 0 && $urandom_range(0, 1))
          free_held($urandom_range(0, held_off.size() - 1));
        else begin
          sz = gran * $urandom_range(1, 4);
          if ($urandom_range(0, 19) == 0) sz = $urandom_range(0, pool_now + 1);
          issue(ffa_pkg::FUNC_ALLOC, sz, $urandom_range(0, (1 << 20) - 1));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: sz = $urandom_range(0, (1 << 21) - 1);
          1: sz = 0;
          default: sz = gran * $urandom_range(1, 3);
        endcase
        off = $urandom_range(0, 1) ? $urandom_range(0, (1 << 20) - 1)
                                   : gran * $urandom_range(0, pool_now / gran + 1);
        issue(1'($urandom_range(0, 1)), sz, off);
      end
    end
  endtask

  // Fill the pool with unit blocks, then free every other one to fill the table
  task automatic comb_phase();
    int n;
    n = int'(pool_now);
    for (int i = 0; i < n; i++) issue(ffa_pkg::FUNC_ALLOC, 1, 0);
    for (int i = 0; i < n; i += 2) issue(ffa_pkg::FUNC_FREE, 1, i);
    held_off.delete();
    held_len.delete();
  endtask

  initial begin
    #60000000;
    $display("first_fit_free_block_allocator: mismatch");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_item       <= '0;
    cfg_we        <= 1'b0;
    cfg_pool_size <= '0;
    no_gaps       = 0;
    pool_now      = 500000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset pool
    issue(ffa_pkg::FUNC_ALLOC, 0, 0);
    issue(ffa_pkg::FUNC_ALLOC, 1000, 0);
    issue(ffa_pkg::FUNC_ALLOC, 500000, 0);
    issue(ffa_pkg::FUNC_FREE, 0, 0);
    issue(ffa_pkg::FUNC_FREE, 1000, 0);
    issue(ffa_pkg::FUNC_FREE, 5, 0);
    issue(ffa_pkg::FUNC_FREE, 21'h1FFFFF, 20'hFFFFF);
    issue(ffa_pkg::FUNC_FREE, 10, 600000);
    issue(ffa_pkg::FUNC_FREE, 100000, 500000);
    issue(ffa_pkg::FUNC_ALLOC, 21'h1FFFFF, 20'hFFFFF);
    issue(ffa_pkg::FUNC_ALLOC, 21'h100000, 0);
    // Directed: empty pool, single-unit pool, oversized pool
    write_pool(0);
    issue(ffa_pkg::FUNC_ALLOC, 0, 0);
    issue(ffa_pkg::FUNC_ALLOC, 5, 0);
    issue(ffa_pkg::FUNC_FREE, 4, 3);
    issue(ffa_pkg::FUNC_ALLOC, 4, 0);
    write_pool(1);
    issue(ffa_pkg::FUNC_ALLOC, 1, 0);
    issue(ffa_pkg::FUNC_ALLOC, 0, 0);
    issue(ffa_pkg::FUNC_FREE, 1, 0);
    write_pool(21'h1FFFFF);
    issue(ffa_pkg::FUNC_ALLOC, 21'h100000, 0);
    issue(ffa_pkg::FUNC_FREE, 21'h100000, 0);
    held_off.delete();
    held_len.delete();

    // Random phases over several pool sizes
    write_pool(200);
    comb_phase();
    random_phase(150, 1);
    write_pool(256);
    random_phase(300, 1);
    write_pool(1 << 20);
    random_phase(250, 4096);
    write_pool(4000);
    random_phase(300, 16);
    write_pool(64);
    random_phase(150, 1);
    write_pool(21'h1FFFFF);
    random_phase(150, 1000);
    write_pool($urandom_range(1, (1 << 21) - 1));
    random_phase(150, 500);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("first_fit_free_block_allocator: match");
    else
      $display("first_fit_free_block_allocator: mismatch");
    $finish;
  end

endmodule

>>> first_fit_free_block_allocator.f
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_free_block_allocator.sv
tb/first_fit_checker.sv
tb/tb_first_fit_free_block_allocator.sv
